### rtl/random_permutation_shuffle_top_macros.svh
`ifndef RANDOM_PERMUTATION_SHUFFLE_TOP_MACROS_SVH
`define RANDOM_PERMUTATION_SHUFFLE_TOP_MACROS_SVH

// Checked only while out of reset.
`define RPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/rps_pkg.sv
`timescale 1ns / 1ps

package rps_pkg;

  localparam int MaxElements = 256;
  localparam int IdxW        = $clog2(MaxElements);
  localparam int CntW        = IdxW + 1;
  localparam int SizeW       = 9;
  localparam int WordW       = 16;
  localparam int OutW        = 8;
  localparam int ProdW       = WordW + CntW;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(256);

  // One shuffle step: position, swap partner, end of run.
  typedef struct packed {
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] swap;
    logic            last;
  } item_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [IdxW-1:0] data;
  } wr_t;

  // Zero counts as one, anything above the table depth saturates.
  function automatic logic [CntW-1:0] eff_size(logic [SizeW-1:0] sz);
    logic [CntW-1:0] n;
    if (sz == '0) begin
      n = CntW'(1);
    end else if (int'(sz) > MaxElements) begin
      n = CntW'(MaxElements);
    end else begin
      n = CntW'(sz);
    end
    return n;
  endfunction

endpackage

### rtl/rps_index.sv
`timescale 1ns / 1ps

module rps_index (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rps_pkg::SizeW-1:0] cfg_data_i,
  input  logic                     accept_i,
  input  logic [rps_pkg::WordW-1:0] random_word_i,
  output rps_pkg::item_t           item_o
);

  logic [rps_pkg::SizeW-1:0] size_q, size_d;
  logic [rps_pkg::IdxW-1:0]  cursor_q, cursor_d;
  logic [rps_pkg::CntW-1:0]  n, rem, offs, j_sum;
  logic [rps_pkg::IdxW-1:0]  pos;
  logic [rps_pkg::ProdW-1:0] prod;

  always_comb begin
    n    = rps_pkg::eff_size(size_q);
    pos  = (rps_pkg::CntW'(cursor_q) >= n) ? '0 : cursor_q;
    rem  = n - rps_pkg::CntW'(pos);
    prod = rps_pkg::ProdW'(random_word_i) * rps_pkg::ProdW'(rem);
    // Fraction times remaining count, integer part only: always below rem.
    offs  = prod[rps_pkg::ProdW-1:rps_pkg::WordW];
    j_sum = rps_pkg::CntW'(pos) + offs;
    item_o.pos  = pos;
    item_o.swap = (j_sum >= n) ? rps_pkg::IdxW'(n - rps_pkg::CntW'(1))
                               : j_sum[rps_pkg::IdxW-1:0];
    item_o.last = (rps_pkg::CntW'(pos) == n - rps_pkg::CntW'(1));
  end

  always_comb begin
    size_d   = size_q;
    cursor_d = cursor_q;
    if (cfg_we_i) begin
      size_d   = cfg_data_i;
      cursor_d = '0;
    end else if (accept_i) begin
      cursor_d = item_o.last ? '0 : pos + rps_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= rps_pkg::SizeReset;
      cursor_q <= '0;
    end else begin
      size_q   <= size_d;
      cursor_q <= cursor_d;
    end
  end

endmodule

### rtl/rps_table.sv
`timescale 1ns / 1ps
`include "random_permutation_shuffle_top_macros.svh"

module rps_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [rps_pkg::IdxW-1:0] rd_addr_a_i,
  input  logic [rps_pkg::IdxW-1:0] rd_addr_b_i,
  input  rps_pkg::wr_t            wr_i,
  input  logic                    clr_i,
  output logic [rps_pkg::IdxW-1:0] rd_a_o,
  output logic [rps_pkg::IdxW-1:0] rd_b_o
);

  logic [rps_pkg::IdxW-1:0]        mem_q [rps_pkg::MaxElements];
  logic [rps_pkg::MaxElements-1:0] valid_q;
  logic [rps_pkg::IdxW-1:0]        rd_a_q, rd_b_q, addr_a_q, addr_b_q;
  rps_pkg::wr_t                    fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q   <= mem_q[rd_addr_a_i];
      rd_b_q   <= mem_q[rd_addr_b_i];
      addr_a_q <= rd_addr_a_i;
      addr_b_q <= rd_addr_b_i;
    end
  end

  // Unwritten entries read as their own index; clearing restores identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_q   <= '0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
        fwd_q   <= '0;
      end else begin
        if (wr_i.en) begin
          valid_q[wr_i.addr] <= 1'b1;
        end
        // Remember the write that raced the read, it is missing from the read data.
        if (rd_en_i) begin
          fwd_q <= wr_i;
        end
      end
    end
  end

  always_comb begin
    if (fwd_q.en && fwd_q.addr == addr_a_q) begin
      rd_a_o = fwd_q.data;
    end else if (valid_q[addr_a_q]) begin
      rd_a_o = rd_a_q;
    end else begin
      rd_a_o = addr_a_q;
    end
    if (fwd_q.en && fwd_q.addr == addr_b_q) begin
      rd_b_o = fwd_q.data;
    end else if (valid_q[addr_b_q]) begin
      rd_b_o = rd_b_q;
    end else begin
      rd_b_o = addr_b_q;
    end
  end

  `RPS_ASSERT(a_clr_empties, clr_i |=> (valid_q == '0), "valid bits survive a clear")
  `RPS_ASSERT(a_wr_marks, wr_i.en && !clr_i |=> valid_q[$past(wr_i.addr)], "write not marked valid")
  `RPS_ASSERT(a_fwd_kept, rd_en_i && wr_i.en && !clr_i |=> fwd_q.en, "racing write not forwarded")

endmodule

### rtl/random_permutation_shuffle_top.sv
`timescale 1ns / 1ps
`include "random_permutation_shuffle_top_macros.svh"
// Fisher-Yates permutation generator.
// Each transfer on the slave stream brings one 16-bit random fraction; each
// produces exactly one transfer on the master stream carrying the element
// placed at the current position, the position itself, and tlast on the
// final element of a run. The next run starts with the next input transfer.
// Run length comes from the configuration channel (0 acts as 1, values above
// the table depth saturates); a configuration transfer restarts the run and
// is held off while an item still waits for its table read or swap write.
// Throughput: one item per cycle while the master side does not stall. The table is a 1-write 2-read RAM with
// registered read data; the swap write of one item is forwarded to the reads
// of the next, so consecutive items never wait on each other.
// An item passes the offset multiply into the s1 register, the table read
// alongside s2, then the output register.
// Reset: run length 256, cursor at zero, table identity, output empty.
// The table returns to identity at once at the end of every run, no sweep.
// A stalled master side freezes the whole pipeline; the slave side keeps
// accepting until the first stage is occupied.

module random_permutation_shuffle_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] random_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] perm_value, [15:8] position
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i       // perm_size
);

  logic                     adv, accept, cfg_fire;
  rps_pkg::item_t           item, s1_q, s2_q;
  logic                     s1_valid_q, s1_valid_d, s2_valid_q, out_valid_q;
  logic [rps_pkg::IdxW-1:0] rd_a, rd_b;
  rps_pkg::wr_t             wr;
  logic                     clr;
  logic [rps_pkg::OutW-1:0] value_q, pos_q;
  logic                     last_q;

  // Hold configuration until no item still needs the table.
  assign cfg_ready_o     = !s1_valid_q && !s2_valid_q;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (adv || !s1_valid_q) && !cfg_fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rps_index u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_fire),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .random_word_i(s_axis_tdata_i),
    .item_o       (item)
  );

  // Only the partner entry needs the old value at the current position.
  always_comb begin
    wr.en   = adv && s2_valid_q;
    wr.addr = s2_q.swap;
    wr.data = rd_a;
    clr     = cfg_fire || (adv && s2_valid_q && s2_q.last);
  end

  rps_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (adv),
    .rd_addr_a_i(s1_q.pos),
    .rd_addr_b_i(s1_q.swap),
    .wr_i       (wr),
    .clr_i      (clr),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready_o) begin
      s1_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (adv) begin
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item;
    end
    if (adv) begin
      s2_q    <= s1_q;
      value_q <= rps_pkg::OutW'(rd_b);
      pos_q   <= rps_pkg::OutW'(s2_q.pos);
      last_q  <= s2_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {pos_q, value_q};
  assign m_axis_tlast_o  = last_q;

  `RPS_ASSERT(a_swap_ahead, s1_valid_q |-> (s1_q.swap >= s1_q.pos), "swap partner behind cursor")
  `RPS_ASSERT(a_last_self, s1_valid_q && s1_q.last |-> (s1_q.swap == s1_q.pos), "last step swaps")
  `RPS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid_o, "output valid in reset")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned StimItems  = 1650;
  localparam int unsigned DrainWait  = 10;

  typedef struct packed {
    logic [7:0] elem;
    logic [7:0] pos;
    logic       last;
  } perm_elem_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      feed_valid = 1'b0;
  logic [rps_pkg::WordW-1:0] feed_word  = '0;
  logic                      sink_ready = 1'b0;
  logic                      cfg_valid  = 1'b0;
  logic [rps_pkg::SizeW-1:0] cfg_data   = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;

  // Shuffle predictor state
  logic [rps_pkg::SizeW-1:0] size_reg;
  logic [7:0]                perm_tbl [rps_pkg::MaxElements];
  int unsigned               cursor_pos;

  logic [rps_pkg::WordW-1:0] fraction_q [$];
  perm_elem_t                pending_elems [$];

  int unsigned err_cnt    = 0;
  int unsigned elem_cnt   = 0;
  int unsigned run_cnt    = 0;
  int unsigned cfg_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned feed_hold  = 0;
  int unsigned sink_stall = 0;
  int unsigned calm_cnt   = 0;
  logic        calm       = 1'b0;

  always #1 clk_i = ~clk_i;

  random_permutation_shuffle_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (feed_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (feed_word),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  function automatic int unsigned clamp_size(logic [rps_pkg::SizeW-1:0] sz);
    if (sz == '0) begin
      return 1;
    end else if (int'(sz) > rps_pkg::MaxElements) begin
      return rps_pkg::MaxElements;
    end
    return int'(sz);
  endfunction

  function automatic void restart_run();
    for (int k = 0; k < rps_pkg::MaxElements; k++) begin
      perm_tbl[k] = 8'(k);
    end
    cursor_pos = 0;
  endfunction

  // One Fisher-Yates step: pick partner from the fraction, swap, emit slot i.
  function automatic void shuffle_step(logic [rps_pkg::WordW-1:0] frac);
    int unsigned n;
    int unsigned i;
    int unsigned partner;
    logic [7:0]  tmp;
    perm_elem_t  res;
    n = clamp_size(size_reg);
    i = (cursor_pos >= n) ? 0 : cursor_pos;
    partner = i + ((int'(frac) * (n - i)) >> 16);
    if (partner >= n) begin
      partner = n - 1;
    end
    tmp               = perm_tbl[i];
    perm_tbl[i]       = perm_tbl[partner];
    perm_tbl[partner] = tmp;
    res.elem = perm_tbl[i];
    res.pos  = 8'(i);
    res.last = (i == n - 1);
    pending_elems.push_back(res);
    if (res.last) begin
      restart_run();
    end else begin
      cursor_pos = i + 1;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [rps_pkg::WordW-1:0] pick_fraction();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return rps_pkg::WordW'($urandom_range(0, 65535));
  endfunction

  // Alternate between stretches with random gaps and stalls and full-rate stretches.
  always @(negedge clk_i) begin
    if (calm_cnt == 0) begin
      calm     = ~calm;
      calm_cnt = $urandom_range(50, 400);
    end else begin
      calm_cnt--;
    end
  end

  always @(posedge clk_i) begin : feed
    logic                      nxt_valid;
    logic [rps_pkg::WordW-1:0] nxt_word;
    nxt_valid = feed_valid;
    nxt_word  = feed_word;
    if (rst_ni) begin
      if (feed_valid && s_axis_tready_o) begin
        shuffle_step(feed_word);
        nxt_valid = 1'b0;
        feed_hold = calm ? 0 : pick_gap();
      end
      if (!nxt_valid) begin
        if (feed_hold != 0) begin
          feed_hold--;
        end else if (fraction_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_word  = fraction_q.pop_front();
        end
      end
    end
    feed_valid <= nxt_valid;
    feed_word  <= nxt_word;
  end

  always @(posedge clk_i) begin : sink
    perm_elem_t got;
    perm_elem_t want;
    logic       nxt_ready;
    nxt_ready = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && sink_ready) begin
        got.elem = m_axis_tdata_o[7:0];
        got.pos  = m_axis_tdata_o[15:8];
        got.last = m_axis_tlast_o;
        elem_cnt++;
        if (pending_elems.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, got elem %0d pos %0d last %0b",
                   $time, got.elem, got.pos, got.last);
          err_cnt++;
        end else begin
          want = pending_elems.pop_front();
          if (want.last) begin
            run_cnt++;
          end
          if (got.elem !== want.elem) begin
            $display("%0t: perm_value mismatch: expected %0d, got %0d",
                     $time, want.elem, got.elem);
            err_cnt++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: position mismatch: expected %0d, got %0d",
                     $time, want.pos, got.pos);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $display("%0t: tlast mismatch at position %0d: expected %0b, got %0b",
                     $time, want.pos, want.last, got.last);
            err_cnt++;
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        sink_stall = pick_gap();
      end else begin
        nxt_ready = 1'b1;
      end
    end
    sink_ready <= nxt_ready;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d transfers still expected", $time, pending_elems.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    while (fraction_q.size() != 0 || feed_valid || pending_elems.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write the run length; any write abandons the run in progress.
  task automatic write_perm_size(input logic [rps_pkg::SizeW-1:0] sz);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    size_reg = sz;
    restart_run();
    cfg_cnt++;
  endtask

  task automatic push_fractions(input int unsigned cnt, inout int unsigned sent);
    for (int unsigned k = 0; k < cnt; k++) begin
      fraction_q.push_back(pick_fraction());
    end
    sent += cnt;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned cnt;
    int unsigned r;
    logic [rps_pkg::SizeW-1:0] sz;
    sent     = 0;
    size_reg = rps_pkg::SizeReset;
    restart_run();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes at the reset length, then the size corner cases.
    fraction_q = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE};
    sent += 5;
    write_perm_size(9'd0);
    fraction_q = '{16'h0000, 16'hFFFF};
    sent += 2;
    write_perm_size(9'd1);
    fraction_q = '{16'hFFFF};
    sent += 1;
    write_perm_size(9'd2);
    fraction_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
    sent += 4;
    write_perm_size(9'd511);
    fraction_q = '{16'hFFFF, 16'h0000, 16'h5555};
    sent += 3;
    write_perm_size(9'd257);
    fraction_q = '{16'hAAAA, 16'hFFFF};
    sent += 2;
    write_perm_size(9'd3);
    fraction_q = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000};
    sent += 7;

    // Random: mostly whole runs, some cut short by the next write.
    while (sent < StimItems) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        sz = 9'($urandom_range(1, 16));
      end else if (r < 85) begin
        sz = 9'($urandom_range(17, 255));
      end else if (r < 92) begin
        sz = ($urandom_range(0, 1) != 0) ? 9'd256 : 9'd0;
      end else begin
        sz = 9'($urandom_range(257, 511));
      end
      if ($urandom_range(0, 4) != 0) begin
        write_perm_size(sz);
      end
      n = clamp_size(size_reg);
      if (n > 64) begin
        cnt = ($urandom_range(0, 2) != 0) ? n : $urandom_range(1, n);
      end else begin
        cnt = n * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) begin
          cnt += $urandom_range(0, n - 1);
        end
      end
      push_fractions(cnt, sent);
      wait_idle();
    end

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (pending_elems.size() != 0) begin
      $display("%0t: %0d transfers never arrived", $time, pending_elems.size());
      err_cnt++;
    end
    $display("Shuffled %0d fractions into %0d checked elements, %0d complete runs,",
             sent, elem_cnt, run_cnt);
    $display("across %0d run-length writes; %0d mismatches.", cfg_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
